// ===== src/sialu_pkg.sv =====
package sialu_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADDI   = 5'd1,
    OP_ADDIU  = 5'd2,
    OP_ADDU   = 5'd3,
    OP_DADD   = 5'd4,
    OP_DADDI  = 5'd5,
    OP_DADDIU = 5'd6,
    OP_DADDU  = 5'd7,
    OP_DSUB   = 5'd8,
    OP_DSUBU  = 5'd9,
    OP_SUB    = 5'd10,
    OP_SUBU   = 5'd11,
    OP_PADDB  = 5'd12,
    OP_PADDH  = 5'd13,
    OP_PADDSB = 5'd14,
    OP_PADDSH = 5'd15,
    OP_PADDSW = 5'd16,
    OP_PADDUB = 5'd17,
    OP_PADDUH = 5'd18,
    OP_PADDUW = 5'd19,
    OP_PADDW  = 5'd20,
    OP_PADSBH = 5'd21,
    OP_PSUBB  = 5'd22,
    OP_PSUBH  = 5'd23,
    OP_PSUBSB = 5'd24,
    OP_PSUBSH = 5'd25,
    OP_PSUBSW = 5'd26,
    OP_PSUBUB = 5'd27,
    OP_PSUBUH = 5'd28,
    OP_PSUBUW = 5'd29,
    OP_PSUBW  = 5'd30
  } opcode_t;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned SIGN_POS  = 31;
  localparam int unsigned HALF_BITS = 64;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned EXT_BITS  = WORD_BITS + 2;

  typedef enum logic [1:0] {
    LW_8,
    LW_16,
    LW_32
  } lane_width_t;

  typedef enum logic [1:0] {
    LM_WRAP,
    LM_SSAT,
    LM_USAT
  } lane_mode_t;

  typedef struct packed {
    lane_width_t width;
    lane_mode_t  mode;
    logic        sub;
    logic        split;
    logic        valid;
  } par_dec_t;

  typedef struct packed {
    lane_width_t width;
    lane_mode_t  mode;
    logic        sub;
  } lane_ctrl_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] sum;
    logic                 write;
    logic                 ovf;
  } scal_res_t;

  function automatic par_dec_t par_decode(input opcode_t op);
    par_dec_t d;
    d = '{width: LW_8, mode: LM_WRAP, sub: 1'b0, split: 1'b0, valid: 1'b1};
    case (op)
      OP_PADDB:  begin d.width = LW_8;  d.mode = LM_WRAP; end
      OP_PADDH:  begin d.width = LW_16; d.mode = LM_WRAP; end
      OP_PADDSB: begin d.width = LW_8;  d.mode = LM_SSAT; end
      OP_PADDSH: begin d.width = LW_16; d.mode = LM_SSAT; end
      OP_PADDSW: begin d.width = LW_32; d.mode = LM_SSAT; end
      OP_PADDUB: begin d.width = LW_8;  d.mode = LM_USAT; end
      OP_PADDUH: begin d.width = LW_16; d.mode = LM_USAT; end
      OP_PADDUW: begin d.width = LW_32; d.mode = LM_USAT; end
      OP_PADDW:  begin d.width = LW_32; d.mode = LM_WRAP; end
      OP_PADSBH: begin d.width = LW_16; d.mode = LM_WRAP; d.split = 1'b1; end
      OP_PSUBB:  begin d.width = LW_8;  d.mode = LM_WRAP; d.sub = 1'b1; end
      OP_PSUBH:  begin d.width = LW_16; d.mode = LM_WRAP; d.sub = 1'b1; end
      OP_PSUBSB: begin d.width = LW_8;  d.mode = LM_SSAT; d.sub = 1'b1; end
      OP_PSUBSH: begin d.width = LW_16; d.mode = LM_SSAT; d.sub = 1'b1; end
      OP_PSUBSW: begin d.width = LW_32; d.mode = LM_SSAT; d.sub = 1'b1; end
      OP_PSUBUB: begin d.width = LW_8;  d.mode = LM_USAT; d.sub = 1'b1; end
      OP_PSUBUH: begin d.width = LW_16; d.mode = LM_USAT; d.sub = 1'b1; end
      OP_PSUBUW: begin d.width = LW_32; d.mode = LM_USAT; d.sub = 1'b1; end
      OP_PSUBW:  begin d.width = LW_32; d.mode = LM_WRAP; d.sub = 1'b1; end
      default:   d.valid = 1'b0;
    endcase
    return d;
  endfunction

  // One element of width w, right-aligned in a and b; result right-aligned.
  function automatic logic [WORD_BITS-1:0] elem_calc(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b,
    input lane_width_t          w,
    input lane_mode_t           m,
    input logic                 sub
  );
    logic [EXT_BITS-1:0] ax;
    logic [EXT_BITS-1:0] bx;
    logic [EXT_BITS-1:0] r;
    logic [EXT_BITS-1:0] smax;
    logic [EXT_BITS-1:0] smin;
    logic [EXT_BITS-1:0] umax;
    logic                uns;
    uns = (m == LM_USAT);
    case (w)
      LW_8: begin
        ax   = uns ? EXT_BITS'(a[7:0]) : {{(EXT_BITS-8){a[7]}}, a[7:0]};
        bx   = uns ? EXT_BITS'(b[7:0]) : {{(EXT_BITS-8){b[7]}}, b[7:0]};
        smax = EXT_BITS'(8'h7f);
        smin = {{(EXT_BITS-7){1'b1}}, 7'h00};
        umax = EXT_BITS'(8'hff);
      end
      LW_16: begin
        ax   = uns ? EXT_BITS'(a[15:0]) : {{(EXT_BITS-16){a[15]}}, a[15:0]};
        bx   = uns ? EXT_BITS'(b[15:0]) : {{(EXT_BITS-16){b[15]}}, b[15:0]};
        smax = EXT_BITS'(16'h7fff);
        smin = {{(EXT_BITS-15){1'b1}}, 15'h0000};
        umax = EXT_BITS'(16'hffff);
      end
      default: begin
        ax   = uns ? EXT_BITS'(a) : {{(EXT_BITS-WORD_BITS){a[SIGN_POS]}}, a};
        bx   = uns ? EXT_BITS'(b) : {{(EXT_BITS-WORD_BITS){b[SIGN_POS]}}, b};
        smax = EXT_BITS'(32'h7fff_ffff);
        smin = {{(EXT_BITS-SIGN_POS){1'b1}}, 31'h0};
        umax = EXT_BITS'(32'hffff_ffff);
      end
    endcase
    r = sub ? (ax - bx) : (ax + bx);
    case (m)
      LM_SSAT: begin
        if ($signed(r) > $signed(smax)) begin
          r = smax;
        end else if ($signed(r) < $signed(smin)) begin
          r = smin;
        end
      end
      LM_USAT: begin
        if (r[EXT_BITS-1]) begin
          r = '0;
        end else if ($signed(r) > $signed(umax)) begin
          r = umax;
        end
      end
      default: ;
    endcase
    return r[WORD_BITS-1:0];
  endfunction

endpackage

// ===== src/sialu_if.sv =====
interface sialu_in_if;
  import sialu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [4:0]           kind;
  logic [HALF_BITS-1:0] first_low;
  logic [HALF_BITS-1:0] first_high;
  logic [HALF_BITS-1:0] second_low;
  logic [HALF_BITS-1:0] second_high;
  logic signed [15:0]   immediate;

  modport source (
    output valid, kind, first_low, first_high, second_low, second_high, immediate,
    input  ready
  );
  modport sink (
    input  valid, kind, first_low, first_high, second_low, second_high, immediate,
    output ready
  );
endinterface

interface sialu_out_if;
  import sialu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [HALF_BITS-1:0] sum_low;
  logic [HALF_BITS-1:0] sum_high;
  logic                 write_low;
  logic                 write_high;
  logic                 overflow;

  modport source (
    output valid, sum_low, sum_high, write_low, write_high, overflow,
    input  ready
  );
  modport sink (
    input  valid, sum_low, sum_high, write_low, write_high, overflow,
    output ready
  );
endinterface

// ===== src/simd_integer_add_sub_alu_unit.sv =====
// Integer and packed add/subtract unit for an execute stage. Takes one opcode,
// two 128-bit operands as 64-bit halves and a 16-bit immediate per transfer and
// returns one result. Scalar forms (32/64-bit, trapping or not) write the low
// half only; a trapping form that overflows writes nothing and flags overflow.
// Packed forms run four 32-bit lanes side by side, each splitting into bytes,
// halfwords or one word with wrap, signed or unsigned saturation. The result is
// registered: it sits in the output register the cycle after the input
// transfer, and a new input is taken every cycle while the output is free or
// being drained in that same cycle.
module simd_integer_add_sub_alu_unit
  import sialu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sialu_in_if.sink   in_ch,
  sialu_out_if.source out_ch
);

  opcode_t              op;
  par_dec_t             pd;
  scal_res_t            sres;
  lane_ctrl_t           lctrl [NUM_LANES];
  logic [WORD_BITS-1:0] lres  [NUM_LANES];
  logic [HALF_BITS-1:0] a_all [2];
  logic [HALF_BITS-1:0] b_all [2];

  logic                 out_valid_r;
  logic [HALF_BITS-1:0] sum_low_r;
  logic [HALF_BITS-1:0] sum_high_r;
  logic                 write_low_r;
  logic                 write_high_r;
  logic                 overflow_r;

  logic [HALF_BITS-1:0] sum_low_nxt;
  logic [HALF_BITS-1:0] sum_high_nxt;
  logic                 write_low_nxt;
  logic                 write_high_nxt;
  logic                 overflow_nxt;
  logic                 in_xfer;

  assign op = opcode_t'(in_ch.kind);
  assign pd = par_decode(op);

  assign a_all[0] = in_ch.first_low;
  assign a_all[1] = in_ch.first_high;
  assign b_all[0] = in_ch.second_low;
  assign b_all[1] = in_ch.second_high;

  sialu_scalar u_scalar (
    .op  (op),
    .a   (in_ch.first_low),
    .b   (in_ch.second_low),
    .imm (in_ch.immediate),
    .res (sres)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam int unsigned HALF_IDX = (i * WORD_BITS) / HALF_BITS;
    localparam int unsigned OFFS     = (i * WORD_BITS) % HALF_BITS;

    // low half subtracts, high half adds for the split form
    assign lctrl[i].width = pd.width;
    assign lctrl[i].mode  = pd.mode;
    assign lctrl[i].sub   = pd.split ? (HALF_IDX == 0) : pd.sub;

    sialu_lane u_lane (
      .a    (a_all[HALF_IDX][OFFS +: WORD_BITS]),
      .b    (b_all[HALF_IDX][OFFS +: WORD_BITS]),
      .ctrl (lctrl[i]),
      .res  (lres[i])
    );
  end

  always_comb begin
    if (in_ch.kind <= OP_SUBU) begin
      sum_low_nxt    = sres.sum;
      sum_high_nxt   = '0;
      write_low_nxt  = sres.write;
      write_high_nxt = 1'b0;
      overflow_nxt   = sres.ovf;
    end else if (pd.valid) begin
      sum_low_nxt    = {lres[1], lres[0]};
      sum_high_nxt   = {lres[3], lres[2]};
      write_low_nxt  = 1'b1;
      write_high_nxt = 1'b1;
      overflow_nxt   = 1'b0;
    end else begin
      sum_low_nxt    = '0;
      sum_high_nxt   = '0;
      write_low_nxt  = 1'b0;
      write_high_nxt = 1'b0;
      overflow_nxt   = 1'b0;
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sum_low_r    <= sum_low_nxt;
      sum_high_r   <= sum_high_nxt;
      write_low_r  <= write_low_nxt;
      write_high_r <= write_high_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sum_low    = sum_low_r;
  assign out_ch.sum_high   = sum_high_r;
  assign out_ch.write_low  = write_low_r;
  assign out_ch.write_high = write_high_r;
  assign out_ch.overflow   = overflow_r;

endmodule

// ===== src/sialu_lane.sv =====
module sialu_lane
  import sialu_pkg::*;
(
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  lane_ctrl_t           ctrl,
  output logic [WORD_BITS-1:0] res
);

  logic [WORD_BITS-1:0] byte_res;
  logic [WORD_BITS-1:0] half_res;
  logic [WORD_BITS-1:0] word_res;

  for (genvar i = 0; i < 4; i++) begin : g_byte
    logic [WORD_BITS-1:0] e;
    assign e = elem_calc(WORD_BITS'(a[i*8 +: 8]), WORD_BITS'(b[i*8 +: 8]),
                         LW_8, ctrl.mode, ctrl.sub);
    assign byte_res[i*8 +: 8] = e[7:0];
  end

  for (genvar i = 0; i < 2; i++) begin : g_half
    logic [WORD_BITS-1:0] e;
    assign e = elem_calc(WORD_BITS'(a[i*16 +: 16]), WORD_BITS'(b[i*16 +: 16]),
                         LW_16, ctrl.mode, ctrl.sub);
    assign half_res[i*16 +: 16] = e[15:0];
  end

  assign word_res = elem_calc(a, b, LW_32, ctrl.mode, ctrl.sub);

  always_comb begin
    case (ctrl.width)
      LW_8:    res = byte_res;
      LW_16:   res = half_res;
      default: res = word_res;
    endcase
  end

endmodule

// ===== src/sialu_scalar.sv =====
module sialu_scalar
  import sialu_pkg::*;
(
  input  opcode_t              op,
  input  logic [HALF_BITS-1:0] a,
  input  logic [HALF_BITS-1:0] b,
  input  logic signed [15:0]   imm,
  output scal_res_t            res
);

  logic                 is64;
  logic                 sub;
  logic                 use_imm;
  logic                 trap;
  logic [HALF_BITS-1:0] bx;
  logic [HALF_BITS-1:0] r64;
  logic                 ovf64;
  logic [WORD_BITS:0]   r32;
  logic                 ovf32;
  logic [HALF_BITS-1:0] r;
  logic                 ovf;

  always_comb begin
    is64    = 1'b0;
    sub     = 1'b0;
    use_imm = 1'b0;
    trap    = 1'b0;
    case (op)
      OP_ADD:    trap = 1'b1;
      OP_ADDI:   begin trap = 1'b1; use_imm = 1'b1; end
      OP_ADDIU:  use_imm = 1'b1;
      OP_ADDU:   ;
      OP_DADD:   begin is64 = 1'b1; trap = 1'b1; end
      OP_DADDI:  begin is64 = 1'b1; trap = 1'b1; use_imm = 1'b1; end
      OP_DADDIU: begin is64 = 1'b1; use_imm = 1'b1; end
      OP_DADDU:  is64 = 1'b1;
      OP_DSUB:   begin is64 = 1'b1; trap = 1'b1; sub = 1'b1; end
      OP_DSUBU:  begin is64 = 1'b1; sub = 1'b1; end
      OP_SUB:    begin trap = 1'b1; sub = 1'b1; end
      OP_SUBU:   sub = 1'b1;
      default:   ;
    endcase
  end

  assign bx = use_imm ? {{(HALF_BITS-16){imm[15]}}, imm} : b;

  assign r64   = sub ? (a - bx) : (a + bx);
  assign ovf64 = sub ? ((a[HALF_BITS-1] ^ bx[HALF_BITS-1]) & (a[HALF_BITS-1] ^ r64[HALF_BITS-1]))
                     : (~(a[HALF_BITS-1] ^ bx[HALF_BITS-1]) &
                        (a[HALF_BITS-1] ^ r64[HALF_BITS-1]));

  assign r32 = sub ? ({a[SIGN_POS], a[WORD_BITS-1:0]} - {bx[SIGN_POS], bx[WORD_BITS-1:0]})
                   : ({a[SIGN_POS], a[WORD_BITS-1:0]} + {bx[SIGN_POS], bx[WORD_BITS-1:0]});
  assign ovf32 = r32[WORD_BITS] ^ r32[SIGN_POS];

  assign r   = is64 ? r64 : {{(HALF_BITS-WORD_BITS){r32[SIGN_POS]}}, r32[WORD_BITS-1:0]};
  assign ovf = is64 ? ovf64 : ovf32;

  always_comb begin
    if (trap && ovf) begin
      res.sum   = '0;
      res.write = 1'b0;
      res.ovf   = 1'b1;
    end else begin
      res.sum   = r;
      res.write = 1'b1;
      res.ovf   = 1'b0;
    end
  end

endmodule
